>>> rtl/video_bitrate_adapter_assert.svh
// Assertion macros used by the checker file.
`ifndef VIDEO_BITRATE_ADAPTER_ASSERT_SVH
`define VIDEO_BITRATE_ADAPTER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define VBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define VBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/vba_pkg.sv
`timescale 1ns / 1ps

package vba_pkg;

  localparam int RATE_W = 27;
  localparam int FPS_W  = 7;
  localparam int MEAS_W = 32;
  localparam int OP_W   = 2;
  localparam int IDX_W  = 2;

  // stream payload widths
  localparam int S_DATA_W = 64;
  localparam int M_DATA_W = 32;

  // shared divider
  localparam int DIV_W    = 30;
  localparam int DVS_W    = 14;
  localparam int DIV_CNT_W = 5;

  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_FRAME = 2'd1;
  localparam logic [OP_W-1:0] OP_LIMIT = 2'd2;

  localparam logic [IDX_W-1:0] CFG_MAX_BITRATE = 2'd0;
  localparam logic [IDX_W-1:0] CFG_FRAME_RATE  = 2'd1;

  localparam logic [RATE_W-1:0] MAX_BITRATE_RST = 27'd1000000;
  localparam logic [FPS_W-1:0]  FRAME_RATE_RST  = 7'd30;

  // max(8*cur, 1e6) floor for the increase numerator
  localparam logic [DIV_W-1:0] MIN_STEP_SCALED = 30'd1000000;
  // 0.8 = 4/5
  localparam logic [DVS_W-1:0] START_DIVISOR = 14'd5;

endpackage

>>> rtl/video_bitrate_adapter.sv
`timescale 1ns / 1ps

// Per-frame encoder bitrate adapter. Each item on the s_ stream returns exactly
// one result on the m_ stream. A start item, and a frame item that takes the
// growth branch, run one shared restoring divider, one quotient bit per cycle
// (floor(4*max/5) for start, max(8*cur, 1e6) divided by 100*fps for frames),
// in the states idle, calc, div and apply; every other item skips the div
// state. m_tvalid rises in the same cycle that s_tready returns, when the apply
// state ends. s_tready is low while an item is in work. A finished result sits
// in the output register, so the next item can be taken while it waits; an
// item that finishes while the previous result is still stalled holds in its
// last step until m_tready. Configuration writes are always ready and must
// only be issued while the block is idle.
module video_bitrate_adapter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // window_full[0], measured_rate[32:1], new_limit[59:33], zero pad
  input  logic [vba_pkg::S_DATA_W-1:0]     s_tdata,
  // op[1:0]
  input  logic [vba_pkg::OP_W-1:0]         s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // current_rate[26:0], rate_changed[27], zero pad
  output logic [vba_pkg::M_DATA_W-1:0]     m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vba_pkg::IDX_W-1:0]        cfg_index,
  input  logic [vba_pkg::RATE_W-1:0]       cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_DIV, ST_APPLY} state_t;

  state_t state;

  logic [vba_pkg::RATE_W-1:0]    max_bitrate;
  logic [vba_pkg::FPS_W-1:0]     frame_rate;
  logic [vba_pkg::RATE_W-1:0]    rate_now;
  logic [vba_pkg::RATE_W-1:0]    rate_cap;
  logic [vba_pkg::FPS_W-1:0]     hold_count;

  // latched item
  logic [vba_pkg::OP_W-1:0]      op;
  logic                          window_full;
  logic [vba_pkg::MEAS_W-1:0]    measured_rate;
  logic [vba_pkg::RATE_W-1:0]    new_limit;
  logic                          grow;

  // divider
  logic [vba_pkg::DIV_W-1:0]     quo;
  logic [vba_pkg::DVS_W-1:0]     rem;
  logic [vba_pkg::DVS_W-1:0]     dvs;
  logic [vba_pkg::DIV_CNT_W-1:0] div_cnt;

  logic [vba_pkg::RATE_W-1:0]    current_rate;
  logic                          rate_changed;

  logic                          s_fire;
  logic                          out_free;
  logic [vba_pkg::FPS_W-1:0]     fps_eff;
  logic [vba_pkg::DVS_W-1:0]     fps_div;
  logic [vba_pkg::DIV_W-1:0]     scaled;
  logic                          grow_now;
  logic [vba_pkg::DVS_W:0]       rem_sh;
  logic                          rem_ge;
  logic [vba_pkg::DVS_W:0]       rem_diff;
  logic [vba_pkg::RATE_W:0]      grown;
  logic [vba_pkg::RATE_W:0]      target_raw;
  logic [vba_pkg::RATE_W-1:0]    target;
  logic [vba_pkg::RATE_W-1:0]    rate_next;
  logic                          changed_next;

  assign s_tready  = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {{(vba_pkg::M_DATA_W - vba_pkg::RATE_W - 1){1'b0}},
                      rate_changed, current_rate};

  always_comb begin
    fps_eff = (frame_rate == '0) ? vba_pkg::FPS_W'(1) : frame_rate;
    // 100*fps = 64*fps + 32*fps + 4*fps
    fps_div = vba_pkg::DVS_W'({fps_eff, 6'b0}) + vba_pkg::DVS_W'({fps_eff, 5'b0})
            + vba_pkg::DVS_W'({fps_eff, 2'b0});
    scaled  = {rate_now, 3'b000};
    if (scaled < vba_pkg::MIN_STEP_SCALED) begin
      scaled = vba_pkg::MIN_STEP_SCALED;
    end
    grow_now = window_full &&
               ((hold_count != '0) || (measured_rate < {5'b0, rate_cap}));

    rem_sh   = {rem, quo[vba_pkg::DIV_W-1]};
    rem_ge   = (rem_sh >= {1'b0, dvs});
    rem_diff = rem_sh - {1'b0, dvs};

    grown = {1'b0, rate_now} + {1'b0, quo[vba_pkg::RATE_W-1:0]}
          + (vba_pkg::RATE_W+1)'(1);
    if (!window_full) begin
      target_raw = {1'b0, rate_now};
    end else if (grow) begin
      target_raw = grown;
    end else begin
      target_raw = {1'b0, rate_cap};
    end
    if (target_raw > {1'b0, max_bitrate}) begin
      target = max_bitrate;
    end else begin
      target = target_raw[vba_pkg::RATE_W-1:0];
    end

    rate_next    = rate_now;
    changed_next = 1'b0;
    case (op)
      vba_pkg::OP_START: begin
        rate_next    = quo[vba_pkg::RATE_W-1:0];
        changed_next = 1'b1;
      end
      vba_pkg::OP_FRAME: begin
        if (target != '0 && target != rate_now) begin
          rate_next    = target;
          changed_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      m_tvalid    <= 1'b0;
      max_bitrate <= vba_pkg::MAX_BITRATE_RST;
      frame_rate  <= vba_pkg::FRAME_RATE_RST;
      rate_now    <= '0;
      rate_cap    <= '0;
      hold_count  <= '0;
    end else begin
      // a result issued this cycle takes over the output register instead
      if (m_tvalid && m_tready && state != ST_APPLY) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vba_pkg::CFG_MAX_BITRATE: max_bitrate <= cfg_data;
          vba_pkg::CFG_FRAME_RATE:  frame_rate  <= cfg_data[vba_pkg::FPS_W-1:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            op            <= s_tuser;
            window_full   <= s_tdata[0];
            measured_rate <= s_tdata[vba_pkg::MEAS_W:1];
            new_limit     <= s_tdata[vba_pkg::MEAS_W+vba_pkg::RATE_W:vba_pkg::MEAS_W+1];
            state         <= ST_CALC;
          end
        end

        ST_CALC: begin
          grow    <= grow_now;
          rem     <= '0;
          div_cnt <= '0;
          if (op == vba_pkg::OP_START) begin
            quo   <= {1'b0, max_bitrate, 2'b00};
            dvs   <= vba_pkg::START_DIVISOR;
            state <= ST_DIV;
          end else if (op == vba_pkg::OP_FRAME && grow_now) begin
            quo   <= scaled;
            dvs   <= fps_div;
            state <= ST_DIV;
          end else begin
            state <= ST_APPLY;
          end
        end

        ST_DIV: begin
          quo     <= {quo[vba_pkg::DIV_W-2:0], rem_ge};
          rem     <= rem_ge ? rem_diff[vba_pkg::DVS_W-1:0] : rem_sh[vba_pkg::DVS_W-1:0];
          div_cnt <= div_cnt + vba_pkg::DIV_CNT_W'(1);
          if (div_cnt == vba_pkg::DIV_CNT_W'(vba_pkg::DIV_W - 1)) begin
            state <= ST_APPLY;
          end
        end

        ST_APPLY: begin
          if (out_free) begin
            m_tvalid     <= 1'b1;
            current_rate <= rate_next;
            rate_changed <= changed_next;
            rate_now     <= rate_next;
            state        <= ST_IDLE;
            case (op)
              vba_pkg::OP_LIMIT: begin
                if (new_limit <= max_bitrate) begin
                  rate_cap   <= new_limit;
                  hold_count <= frame_rate;
                end
              end
              vba_pkg::OP_FRAME: begin
                if (hold_count != '0) begin
                  hold_count <= hold_count - vba_pkg::FPS_W'(1);
                end
              end
              default: ;
            endcase
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/vba_checker.sv
`timescale 1ns / 1ps

`include "video_bitrate_adapter_assert.svh"

module vba_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [vba_pkg::S_DATA_W-1:0] s_tdata,
  input logic [vba_pkg::OP_W-1:0]     s_tuser,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [vba_pkg::M_DATA_W-1:0] m_tdata,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [vba_pkg::IDX_W-1:0]    cfg_index,
  input logic [vba_pkg::RATE_W-1:0]   cfg_data
);

  // one item in work at a time
  `VBA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready stayed high after input transaction")

  // a fresh result only comes out of a busy period
  `VBA_ASSERT_NOW(a_result_from_work, $rose(m_tvalid), $past(!s_tready), "result appeared without an item in work")

  // stalled result holds
  `VBA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result dropped or changed")

endmodule

bind video_bitrate_adapter vba_checker u_vba_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam logic [vba_pkg::OP_W-1:0]   OP_UNUSED  = 2'd3;
  localparam logic [vba_pkg::IDX_W-1:0]  CFG_UNUSED = 2'd3;
  localparam logic [vba_pkg::RATE_W-1:0] RATE_ALL_ONES = {vba_pkg::RATE_W{1'b1}};
  localparam logic [vba_pkg::MEAS_W-1:0] MEAS_ALL_ONES = {vba_pkg::MEAS_W{1'b1}};
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [vba_pkg::RATE_W-1:0] rate;
    logic                       changed;
  } rate_update_t;

  // Tracks the adapter state and holds the rate updates still owed by the block.
  class rate_scoreboard;
    logic [vba_pkg::RATE_W-1:0] max_rate;
    logic [vba_pkg::FPS_W-1:0]  fps;
    logic [vba_pkg::RATE_W-1:0] rate_now;
    logic [vba_pkg::RATE_W-1:0] rate_cap;
    logic [vba_pkg::FPS_W-1:0]  hold_left;
    rate_update_t               pending_rates[$];
    int                         errors;

    function new();
      max_rate  = vba_pkg::MAX_BITRATE_RST;
      fps       = vba_pkg::FRAME_RATE_RST;
      rate_now  = '0;
      rate_cap  = '0;
      hold_left = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [vba_pkg::IDX_W-1:0] idx,
                            logic [vba_pkg::RATE_W-1:0] val);
      case (idx)
        vba_pkg::CFG_MAX_BITRATE: max_rate = val;
        vba_pkg::CFG_FRAME_RATE:  fps = val[vba_pkg::FPS_W-1:0];
        default: ;
      endcase
    endfunction

    // step = floor(max(8*cur, 1e6) / (100*fps)) + 1
    function logic [63:0] grown_rate();
      logic [63:0] div;
      logic [63:0] scaled;
      div = (fps == 0) ? 64'd100 : 64'd100 * fps;
      scaled = 64'(rate_now) * 8;
      if (scaled < 64'd1000000)
        scaled = 64'd1000000;
      return 64'(rate_now) + scaled / div + 1;
    endfunction

    function void note_item(logic [vba_pkg::OP_W-1:0] op, logic full,
                            logic [vba_pkg::MEAS_W-1:0] meas,
                            logic [vba_pkg::RATE_W-1:0] lim);
      rate_update_t upd;
      logic [63:0]  target;
      upd.changed = 1'b0;
      case (op)
        vba_pkg::OP_START: begin
          target = (64'(max_rate) * 4) / 5;
          rate_now = target[vba_pkg::RATE_W-1:0];
          upd.changed = 1'b1;
        end
        vba_pkg::OP_LIMIT: begin
          if (lim <= max_rate) begin
            rate_cap = lim;
            hold_left = fps;
          end
        end
        vba_pkg::OP_FRAME: begin
          target = 64'(rate_now);
          if (full) begin
            if (hold_left != 0 || 64'(meas) < 64'(rate_cap))
              target = grown_rate();
            else
              target = 64'(rate_cap);
          end
          if (target > 64'(max_rate))
            target = 64'(max_rate);
          if (hold_left != 0)
            hold_left = hold_left - 1'b1;
          if (target != 0 && target != 64'(rate_now)) begin
            rate_now = target[vba_pkg::RATE_W-1:0];
            upd.changed = 1'b1;
          end
        end
        default: ;
      endcase
      upd.rate = rate_now;
      pending_rates.push_back(upd);
    endfunction

    task log_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_update(logic [vba_pkg::RATE_W-1:0] rate, logic changed);
      rate_update_t exp_upd;
      if (pending_rates.size() == 0) begin
        log_mismatch($sformatf("unexpected transaction rate=%0d changed=%0b", rate, changed));
      end else begin
        exp_upd = pending_rates.pop_front();
        if (rate !== exp_upd.rate)
          log_mismatch($sformatf("current_rate %0d, expected %0d", rate, exp_upd.rate));
        if (changed !== exp_upd.changed)
          log_mismatch($sformatf("rate_changed %0b, expected %0b", changed, exp_upd.changed));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [vba_pkg::S_DATA_W-1:0] s_tdata = '0;   // window_full, measured_rate, new_limit, pad
  logic [vba_pkg::OP_W-1:0] s_tuser = vba_pkg::OP_START; // op
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [vba_pkg::M_DATA_W-1:0] m_tdata;        // current_rate, rate_changed, pad
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [vba_pkg::IDX_W-1:0] cfg_index = vba_pkg::CFG_MAX_BITRATE;
  logic [vba_pkg::RATE_W-1:0] cfg_data = '0;

  rate_scoreboard sb = new();
  bit quiet = 1'b0;
  int rx_stall = 0;

  always #2 clk = ~clk;

  video_bitrate_adapter dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return $urandom_range(1, 3);
    else if (r < 95)
      return $urandom_range(4, 12);
    return $urandom_range(30, 60);
  endfunction

  // result side: sample the transaction, then pick the next ready
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        sb.check_update(m_tdata[vba_pkg::RATE_W-1:0], m_tdata[vba_pkg::RATE_W]);
      if (rx_stall > 0) begin
        m_tready <= 1'b0;
        rx_stall--;
      end else if (!quiet && $urandom_range(0, 9) < 3) begin
        m_tready <= 1'b0;
        rx_stall = idle_len() - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic [vba_pkg::OP_W-1:0] op, logic full,
                           logic [vba_pkg::MEAS_W-1:0] meas,
                           logic [vba_pkg::RATE_W-1:0] lim);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, lim, meas, full};
    do @(posedge clk); while (!s_tready);
    sb.note_item(op, full, meas, lim);
    gap = (!quiet && $urandom_range(0, 9) < 3) ? idle_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // leaves cfg_valid high so back-to-back writes need no extra edge
  task automatic write_reg(logic [vba_pkg::IDX_W-1:0] idx,
                           logic [vba_pkg::RATE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(logic [vba_pkg::RATE_W-1:0] max_val,
                           logic [vba_pkg::RATE_W-1:0] fps_val);
    if ($urandom_range(0, 1)) begin
      write_reg(vba_pkg::CFG_MAX_BITRATE, max_val);
      write_reg(vba_pkg::CFG_FRAME_RATE, fps_val);
    end else begin
      write_reg(vba_pkg::CFG_FRAME_RATE, fps_val);
      write_reg(vba_pkg::CFG_MAX_BITRATE, max_val);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_rates.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_item();
    logic [vba_pkg::OP_W-1:0]   op;
    logic                       full;
    logic [vba_pkg::MEAS_W-1:0] meas;
    logic [vba_pkg::RATE_W-1:0] lim;
    longint                     near;
    int                         r;
    r = $urandom_range(0, 99);
    if (r < 6)
      op = vba_pkg::OP_START;
    else if (r < 72)
      op = vba_pkg::OP_FRAME;
    else if (r < 94)
      op = vba_pkg::OP_LIMIT;
    else
      op = OP_UNUSED;
    full = ($urandom_range(0, 99) < 85);
    // measured rate straddling the stored limit drives both growth branches
    r = $urandom_range(0, 99);
    if (r < 40) begin
      near = longint'(sb.rate_cap) + $urandom_range(0, 4000) - 2000;
      meas = (near < 0) ? '0 : near[vba_pkg::MEAS_W-1:0];
    end else if (r < 55) begin
      meas = '0;
    end else if (r < 65) begin
      meas = MEAS_ALL_ONES;
    end else begin
      meas = $urandom();
    end
    r = $urandom_range(0, 99);
    if (r < 65)
      lim = vba_pkg::RATE_W'($urandom_range(0, sb.max_rate));
    else if (r < 75)
      lim = sb.max_rate;
    else if (r < 85)
      lim = sb.rate_now;
    else
      lim = vba_pkg::RATE_W'($urandom());
    send_item(op, full, meas, lim);
  endtask

  initial begin
    logic [vba_pkg::RATE_W-1:0] max_val;
    logic [vba_pkg::RATE_W-1:0] fps_val;
    int n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: frames before any start, unused op, limit above and at max
    send_item(vba_pkg::OP_FRAME, 1'b1, '0, '0);
    send_item(vba_pkg::OP_FRAME, 1'b0, MEAS_ALL_ONES, '0);
    send_item(OP_UNUSED, 1'b1, MEAS_ALL_ONES, RATE_ALL_ONES);
    send_item(vba_pkg::OP_LIMIT, 1'b0, '0, RATE_ALL_ONES);
    send_item(vba_pkg::OP_LIMIT, 1'b1, '0, 27'd1000000);
    send_item(vba_pkg::OP_START, 1'b0, '0, '0);
    send_item(vba_pkg::OP_FRAME, 1'b1, MEAS_ALL_ONES, '0);
    send_item(vba_pkg::OP_FRAME, 1'b0, '0, '0);
    drain();

    // one-frame hold, then both sides of the limit comparison
    configure(27'd100000000, 27'd1);
    send_item(vba_pkg::OP_LIMIT, 1'b1, '0, 27'd500000);
    send_item(vba_pkg::OP_START, 1'b1, '0, '0);
    send_item(vba_pkg::OP_FRAME, 1'b1, '0, '0);
    send_item(vba_pkg::OP_FRAME, 1'b1, '0, '0);
    send_item(vba_pkg::OP_FRAME, 1'b1, MEAS_ALL_ONES, '0);
    send_item(vba_pkg::OP_FRAME, 1'b1, 32'd499999, '0);
    send_item(vba_pkg::OP_LIMIT, 1'b0, '0, RATE_ALL_ONES);
    send_item(vba_pkg::OP_FRAME, 1'b1, MEAS_ALL_ONES, '0);
    drain();

    // zero max and zero frame rate; unused register index written too
    write_reg(CFG_UNUSED, vba_pkg::RATE_W'($urandom()));
    configure('0, '0);
    send_item(vba_pkg::OP_START, 1'b0, '0, '0);
    send_item(vba_pkg::OP_LIMIT, 1'b0, '0, '0);
    send_item(vba_pkg::OP_FRAME, 1'b1, '0, '0);
    drain();

    // widest max, top frame rate, growth under a held limit
    configure(RATE_ALL_ONES, 27'd127);
    send_item(vba_pkg::OP_START, 1'b0, '0, '0);
    send_item(vba_pkg::OP_FRAME, 1'b1, '0, '0);
    send_item(vba_pkg::OP_LIMIT, 1'b0, '0, RATE_ALL_ONES);
    send_item(vba_pkg::OP_FRAME, 1'b1, '0, '0);
    send_item(vba_pkg::OP_FRAME, 1'b1, MEAS_ALL_ONES, '0);
    drain();

    for (int p = 0; p < 8; p++) begin
      quiet = (p % 3 == 1);
      if (p == 0) begin
        max_val = 27'd100000000;
        fps_val = 27'd120;
      end else begin
        case ($urandom_range(0, 7))
          0: max_val = '0;
          1: max_val = RATE_ALL_ONES;
          2: max_val = 27'd100000000;
          3: max_val = vba_pkg::RATE_W'($urandom_range(1, 2000));
          4: max_val = vba_pkg::MAX_BITRATE_RST;
          default: max_val = vba_pkg::RATE_W'($urandom_range(0, 100000000));
        endcase
        case ($urandom_range(0, 6))
          0: fps_val = '0;
          1: fps_val = 27'd1;
          2: fps_val = 27'd120;
          3: fps_val = 27'd127;
          4: fps_val = vba_pkg::RATE_W'(vba_pkg::FRAME_RATE_RST);
          default: fps_val = vba_pkg::RATE_W'($urandom_range(1, 120));
        endcase
        // upper data bits are don't-care for the frame rate register
        if ($urandom_range(0, 3) == 0)
          fps_val[vba_pkg::RATE_W-1:vba_pkg::FPS_W] =
            (vba_pkg::RATE_W - vba_pkg::FPS_W)'($urandom());
      end
      configure(max_val, fps_val);
      if ($urandom_range(0, 9) != 0)
        send_item(vba_pkg::OP_START, 1'b0, $urandom(), vba_pkg::RATE_W'($urandom()));
      n = $urandom_range(120, 150);
      for (int i = 0; i < n; i++)
        random_item();
      drain();
    end

    quiet = 1'b0;
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/vba_pkg.sv
rtl/video_bitrate_adapter.sv
rtl/vba_checker.sv
sim/tb.sv
